[src/ebalu_pkg.sv]
package ebalu_pkg;

	// operation codes
	typedef enum logic [4:0] {
		ACT_ADD      = 5'd0,
		ACT_ADC      = 5'd1,
		ACT_SUB      = 5'd2,
		ACT_SBC      = 5'd3,
		ACT_AND      = 5'd4,
		ACT_XOR      = 5'd5,
		ACT_OR       = 5'd6,
		ACT_CP       = 5'd7,
		ACT_INC      = 5'd8,
		ACT_DEC      = 5'd9,
		ACT_RLCA     = 5'd10,
		ACT_RRCA     = 5'd11,
		ACT_RLA      = 5'd12,
		ACT_RRA      = 5'd13,
		ACT_DAA      = 5'd14,
		ACT_CPL      = 5'd15,
		ACT_SCF      = 5'd16,
		ACT_CCF      = 5'd17,
		ACT_RLC      = 5'd18,
		ACT_RRC      = 5'd19,
		ACT_RL       = 5'd20,
		ACT_RR       = 5'd21,
		ACT_SLA      = 5'd22,
		ACT_SRA      = 5'd23,
		ACT_SWAP     = 5'd24,
		ACT_SRL      = 5'd25,
		ACT_BIT      = 5'd26,
		ACT_RES      = 5'd27,
		ACT_SET      = 5'd28,
		ACT_ADD16    = 5'd29,
		ACT_ADD_SP   = 5'd30,
		ACT_LD_HL_SP = 5'd31
	} action_t;

	// flag word, zero in the top bit
	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

	// one request as held in the input register
	typedef struct packed {
		action_t     action;
		logic [15:0] operand;
		logic [15:0] base_word;
		logic [2:0]  bit_index;
		logic        target_is_acc;
	} alu_req_t;

	// one result as held in the output register
	typedef struct packed {
		logic [15:0] result_value;
		logic        write_result;
		logic [7:0]  acc;
		flags_t      flags;
	} alu_res_t;

	localparam logic [7:0] ACC_RESET   = 8'h01;
	localparam flags_t     FLAGS_RESET = '{z: 1'b1, n: 1'b0, h: 1'b1, c: 1'b1};
	localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
	localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;

endpackage

[src/eight_bit_alu_with_flags.sv]
// channel   direction  handshake            payload
// request   in         in_valid / in_ready  action, operand, base_word, bit_index, target_is_acc
// result    out        out_valid / out_ready result_value, write_result, acc_out, four flags
//
// one request per cycle sustained while results are taken; a result passes through the
// input register, then the result register
// accumulator and flags update as a request moves into the result register, so
// the next request already sees them
// reset leaves accumulator 0x01 with zero, half and carry set, both registers empty
// a stalled result holds the result register; the input register still takes one
// more request before in_ready drops
module eight_bit_alu_with_flags
	import ebalu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  action,
	input  logic [15:0] operand,
	input  logic [15:0] base_word,
	input  logic [2:0]  bit_index,
	input  logic        target_is_acc,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] result_value,
	output logic        write_result,
	output logic [7:0]  acc_out,
	output logic        zero_flag,
	output logic        sub_flag,
	output logic        half_flag,
	output logic        carry_flag
);

	logic       valid_s1;
	alu_req_t   req_s1;
	logic       valid_s2;
	alu_res_t   res_s2;
	logic [7:0] acc_q;
	flags_t     flags_q;
	alu_res_t   exec_res;
	logic       s2_load;
	logic       s1_adv;

	// stage flow control
	assign s2_load  = !valid_s2 || out_ready;
	assign s1_adv   = valid_s1 && s2_load;
	assign in_ready = !valid_s1 || s2_load;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= '{action: action_t'(action), operand: operand, base_word: base_word,
				bit_index: bit_index, target_is_acc: target_is_acc};
		end
	end

	ebalu_exec u_exec (
		.req   (req_s1),
		.acc   (acc_q),
		.flags (flags_q),
		.res   (exec_res)
	);

	// accumulator and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= ACC_RESET;
			flags_q <= FLAGS_RESET;
		end else if (s1_adv) begin
			acc_q   <= exec_res.acc;
			flags_q <= exec_res.flags;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_s2 <= exec_res;
		end
	end

	assign out_valid    = valid_s2;
	assign result_value = res_s2.result_value;
	assign write_result = res_s2.write_result;
	assign acc_out      = res_s2.acc;
	assign zero_flag    = res_s2.flags.z;
	assign sub_flag     = res_s2.flags.n;
	assign half_flag    = res_s2.flags.h;
	assign carry_flag   = res_s2.flags.c;

endmodule

[src/ebalu_exec.sv]
module ebalu_exec
	import ebalu_pkg::*;
(
	input  alu_req_t   req,
	input  logic [7:0] acc,
	input  flags_t     flags,
	output alu_res_t   res
);

	logic [7:0]  b;
	logic [7:0]  v;
	logic [8:0]  add_sum;
	logic [4:0]  add_half;
	logic [8:0]  sub_diff;
	logic [4:0]  sub_half;
	logic        use_cin;
	logic [7:0]  inc_r;
	logic [7:0]  dec_r;
	logic [7:0]  sh_r;
	logic        sh_c;
	logic [7:0]  daa_adj;
	logic        daa_c;
	logic [7:0]  daa_r;
	logic [7:0]  bit_mask;
	logic [16:0] w_sum;
	logic [12:0] w_half;
	logic [15:0] sp_sum;
	logic [4:0]  sp_half;
	logic [8:0]  sp_low;

	assign b = req.operand[7:0];
	assign v = req.target_is_acc ? acc : b;

	// adder and subtractor, carry-in only for adc and sbc
	assign use_cin  = (req.action == ACT_ADC || req.action == ACT_SBC) ? flags.c : 1'b0;
	assign add_sum  = {1'b0, acc} + {1'b0, b} + {8'd0, use_cin};
	assign add_half = {1'b0, acc[3:0]} + {1'b0, b[3:0]} + {4'd0, use_cin};
	assign sub_diff = {1'b0, acc} - {1'b0, b} - {8'd0, use_cin};
	assign sub_half = {1'b0, acc[3:0]} - {1'b0, b[3:0]} - {4'd0, use_cin};

	assign inc_r = v + 8'd1;
	assign dec_r = v - 8'd1;

	// decimal adjust
	always_comb begin
		daa_adj = 8'd0;
		daa_c   = 1'b0;
		if (flags.h || (!flags.n && acc[3:0] > 4'd9)) begin
			daa_adj = DAA_LOW_ADJ;
		end
		if (flags.c || (!flags.n && acc > 8'h99)) begin
			daa_adj = daa_adj | DAA_HIGH_ADJ;
			daa_c   = 1'b1;
		end
		daa_r = flags.n ? (acc - daa_adj) : (acc + daa_adj);
	end

	// prefixed rotates and shifts
	always_comb begin
		sh_r = v;
		sh_c = 1'b0;
		case (req.action)
			ACT_RLC: begin
				sh_r = {v[6:0], v[7]};
				sh_c = v[7];
			end
			ACT_RRC: begin
				sh_r = {v[0], v[7:1]};
				sh_c = v[0];
			end
			ACT_RL: begin
				sh_r = {v[6:0], flags.c};
				sh_c = v[7];
			end
			ACT_RR: begin
				sh_r = {flags.c, v[7:1]};
				sh_c = v[0];
			end
			ACT_SLA: begin
				sh_r = {v[6:0], 1'b0};
				sh_c = v[7];
			end
			ACT_SRA: begin
				sh_r = {v[7], v[7:1]};
				sh_c = v[0];
			end
			ACT_SWAP: begin
				sh_r = {v[3:0], v[7:4]};
				sh_c = 1'b0;
			end
			ACT_SRL: begin
				sh_r = {1'b0, v[7:1]};
				sh_c = v[0];
			end
			default: begin
				sh_r = v;
				sh_c = 1'b0;
			end
		endcase
	end

	assign bit_mask = 8'd1 << req.bit_index;

	// sixteen-bit adds
	assign w_sum   = {1'b0, req.base_word} + {1'b0, req.operand};
	assign w_half  = {1'b0, req.base_word[11:0]} + {1'b0, req.operand[11:0]};
	assign sp_sum  = req.base_word + {{8{b[7]}}, b};
	assign sp_half = {1'b0, req.base_word[3:0]} + {1'b0, b[3:0]};
	assign sp_low  = {1'b0, req.base_word[7:0]} + {1'b0, b};

	// result select
	always_comb begin
		res.result_value = 16'd0;
		res.write_result = 1'b0;
		res.acc          = acc;
		res.flags        = flags;
		case (req.action)
			ACT_ADD, ACT_ADC: begin
				res.acc   = add_sum[7:0];
				res.flags = '{z: (add_sum[7:0] == 8'd0), n: 1'b0, h: add_half[4], c: add_sum[8]};
				res.result_value = {8'd0, add_sum[7:0]};
			end
			ACT_SUB, ACT_SBC: begin
				res.acc   = sub_diff[7:0];
				res.flags = '{z: (sub_diff[7:0] == 8'd0), n: 1'b1, h: sub_half[4],
					c: sub_diff[8]};
				res.result_value = {8'd0, sub_diff[7:0]};
			end
			ACT_CP: begin
				res.flags = '{z: (sub_diff[7:0] == 8'd0), n: 1'b1, h: sub_half[4],
					c: sub_diff[8]};
			end
			ACT_AND: begin
				res.acc   = acc & b;
				res.flags = '{z: ((acc & b) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
				res.result_value = {8'd0, acc & b};
			end
			ACT_XOR: begin
				res.acc   = acc ^ b;
				res.flags = '{z: ((acc ^ b) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
				res.result_value = {8'd0, acc ^ b};
			end
			ACT_OR: begin
				res.acc   = acc | b;
				res.flags = '{z: ((acc | b) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
				res.result_value = {8'd0, acc | b};
			end
			ACT_INC: begin
				res.flags = '{z: (inc_r == 8'd0), n: 1'b0, h: (inc_r[3:0] == 4'h0),
					c: flags.c};
				res.result_value = {8'd0, inc_r};
				if (req.target_is_acc) begin
					res.acc = inc_r;
				end else begin
					res.write_result = 1'b1;
				end
			end
			ACT_DEC: begin
				res.flags = '{z: (dec_r == 8'd0), n: 1'b1, h: (dec_r[3:0] == 4'hF),
					c: flags.c};
				res.result_value = {8'd0, dec_r};
				if (req.target_is_acc) begin
					res.acc = dec_r;
				end else begin
					res.write_result = 1'b1;
				end
			end
			ACT_RLCA: begin
				res.acc   = {acc[6:0], acc[7]};
				res.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[7]};
				res.result_value = {8'd0, acc[6:0], acc[7]};
			end
			ACT_RRCA: begin
				res.acc   = {acc[0], acc[7:1]};
				res.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[0]};
				res.result_value = {8'd0, acc[0], acc[7:1]};
			end
			ACT_RLA: begin
				res.acc   = {acc[6:0], flags.c};
				res.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[7]};
				res.result_value = {8'd0, acc[6:0], flags.c};
			end
			ACT_RRA: begin
				res.acc   = {flags.c, acc[7:1]};
				res.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[0]};
				res.result_value = {8'd0, flags.c, acc[7:1]};
			end
			ACT_DAA: begin
				res.acc   = daa_r;
				res.flags = '{z: (daa_r == 8'd0), n: flags.n, h: 1'b0, c: daa_c};
				res.result_value = {8'd0, daa_r};
			end
			ACT_CPL: begin
				res.acc   = ~acc;
				res.flags = '{z: flags.z, n: 1'b1, h: 1'b1, c: flags.c};
				res.result_value = {8'd0, ~acc};
			end
			ACT_SCF: begin
				res.flags = '{z: flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
			end
			ACT_CCF: begin
				res.flags = '{z: flags.z, n: 1'b0, h: 1'b0, c: ~flags.c};
			end
			ACT_RLC, ACT_RRC, ACT_RL, ACT_RR, ACT_SLA, ACT_SRA, ACT_SWAP, ACT_SRL: begin
				res.flags = '{z: (sh_r == 8'd0), n: 1'b0, h: 1'b0, c: sh_c};
				res.result_value = {8'd0, sh_r};
				if (req.target_is_acc) begin
					res.acc = sh_r;
				end else begin
					res.write_result = 1'b1;
				end
			end
			ACT_BIT: begin
				res.flags = '{z: ((v & bit_mask) == 8'd0), n: 1'b0, h: 1'b1, c: flags.c};
			end
			ACT_RES, ACT_SET: begin
				if (req.action == ACT_RES) begin
					res.result_value = {8'd0, v & ~bit_mask};
				end else begin
					res.result_value = {8'd0, v | bit_mask};
				end
				if (req.target_is_acc) begin
					res.acc = res.result_value[7:0];
				end else begin
					res.write_result = 1'b1;
				end
			end
			ACT_ADD16: begin
				res.flags = '{z: flags.z, n: 1'b0, h: w_half[12], c: w_sum[16]};
				res.result_value = w_sum[15:0];
				res.write_result = 1'b1;
			end
			ACT_ADD_SP, ACT_LD_HL_SP: begin
				res.flags = '{z: 1'b0, n: 1'b0, h: sp_half[4], c: sp_low[8]};
				res.result_value = sp_sum;
				res.write_result = 1'b1;
			end
			default: begin
				res.result_value = 16'd0;
			end
		endcase
	end

endmodule

[src/ebalu_checker.sv]
module ebalu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [4:0]  action,
	input logic [15:0] operand,
	input logic [15:0] base_word,
	input logic [2:0]  bit_index,
	input logic        target_is_acc,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] result_value,
	input logic        write_result,
	input logic [7:0]  acc_out,
	input logic        zero_flag,
	input logic        sub_flag,
	input logic        half_flag,
	input logic        carry_flag
);

	// a waiting request holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(action) && $stable(operand)
			&& $stable(base_word) && $stable(bit_index) && $stable(target_is_acc))
		else $error("request changed while waiting");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_value)
			&& $stable(write_result) && $stable(acc_out) && $stable(zero_flag)
			&& $stable(sub_flag) && $stable(half_flag) && $stable(carry_flag))
		else $error("result changed while stalled");

	// empty result register never back-pressures the request side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("in_ready low with no result pending");

	// a new result comes from a request that was taken into the input register
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a request");

	// a request taken into an idle block shows a result after the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |-> ##2 out_valid)
		else $error("result missing after request");

endmodule

bind eight_bit_alu_with_flags ebalu_checker u_ebalu_checker (.*);
